/* hdl/dual_cpu_memory_map_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual processor memory map decoder
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_CPU_MEMORY_MAP_DECODER_MACROS_SVH
`define DUAL_CPU_MEMORY_MAP_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DCMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DCMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dcmm_pkg.sv */
// ----------------------------------------------------------------------------
// dcmm_pkg
// Types, codes and decode functions shared by the memory map decoder.
// ----------------------------------------------------------------------------
package dcmm_pkg;

  localparam logic [4:0] TGT_NONE    = 5'd0;
  localparam logic [4:0] TGT_BOOT2   = 5'd1;
  localparam logic [4:0] TGT_BOOT1   = 5'd2;
  localparam logic [4:0] TGT_RAM     = 5'd3;
  localparam logic [4:0] TGT_HALF0   = 5'd4;
  localparam logic [4:0] TGT_HALF1   = 5'd5;
  localparam logic [4:0] TGT_PRIV    = 5'd6;
  localparam logic [4:0] TGT_VIDMEM  = 5'd7;
  localparam logic [4:0] TGT_PAL     = 5'd8;
  localparam logic [4:0] TGT_SPRITE  = 5'd9;
  localparam logic [4:0] TGT_VIDIO   = 5'd10;
  localparam logic [4:0] TGT_KEYPAD  = 5'd11;
  localparam logic [4:0] TGT_IPC     = 5'd12;
  localparam logic [4:0] TGT_IPCFIFO = 5'd13;
  localparam logic [4:0] TGT_IRQ     = 5'd14;
  localparam logic [4:0] TGT_SHARE   = 5'd15;
  localparam logic [4:0] TGT_VRSTAT  = 5'd16;
  localparam logic [4:0] TGT_MATH    = 5'd17;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_INVALID = 3'd1;
  localparam logic [2:0] ERR_CART    = 3'd2;
  localparam logic [2:0] ERR_IO      = 3'd3;
  localparam logic [2:0] ERR_ROMWR   = 3'd4;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [31:0] ADDR_SHARE    = 32'h0400_0247;
  localparam logic [31:0] ADDR_FIFO_RD  = 32'h0410_0000;
  localparam logic [31:0] ADDR_FIFO_WR  = 32'h0400_0188;
  localparam logic [31:0] ADDR_PRIV_LO  = 32'h0380_0000;

  typedef struct packed {
    logic        cpu;
    logic        wr;
    logic [1:0]  sz;
    logic [31:0] addr;
    logic [31:0] wd;
    logic [31:0] data;
    logic        io;
    logic        fifo;
    logic [1:0]  cnt_m1;
  } req_t;

  typedef struct packed {
    logic [4:0]  target;
    logic [23:0] offset;
    logic [1:0]  width;
    logic [31:0] data;
    logic [2:0]  error_kind;
    logic        last;
  } res_t;

  function automatic logic in_rng(input logic [31:0] a, input logic [31:0] lo,
                                  input logic [31:0] hi);
    in_rng = (a >= lo) && (a <= hi);
  endfunction

  function automatic logic [4:0] io_unit(input logic cpu, input logic wr,
                                         input logic [31:0] a);
    logic keypad;
    logic ipc;
    logic irq;
    logic math;
    logic [4:0] u;
    keypad = wr ? in_rng(a, 32'h0400_0132, 32'h0400_0133)
                : in_rng(a, 32'h0400_0130, 32'h0400_0133);
    ipc  = (a == 32'h0400_0180) || (a == 32'h0400_0181) ||
           (a == 32'h0400_0184) || (a == 32'h0400_0185);
    irq  = in_rng(a, 32'h0400_0208, 32'h0400_020B) ||
           in_rng(a, 32'h0400_0210, 32'h0400_0217);
    math = (a == 32'h0400_0280) || (a == 32'h0400_0281) ||
           in_rng(a, 32'h0400_0290, 32'h0400_02BF);
    u = TGT_NONE;
    if (!cpu) begin
      priority if (in_rng(a, 32'h0400_0004, 32'h0400_0007)) u = TGT_VIDIO;
      else if (keypad)                                     u = TGT_KEYPAD;
      else if (ipc)                                        u = TGT_IPC;
      else if (irq)                                        u = TGT_IRQ;
      else if (!wr && a == 32'h0400_0240)                  u = TGT_VRSTAT;
      else if (!wr && a == 32'h0400_0241)                  u = TGT_SHARE;
      else                                                 u = TGT_NONE;
    end else begin
      priority if (in_rng(a, 32'h0400_0000, 32'h0400_0058)) u = TGT_VIDIO;
      else if (wr && in_rng(a, 32'h0400_0240, 32'h0400_0249) && a != ADDR_SHARE)
        u = TGT_VIDIO;
      else if (keypad)          u = TGT_KEYPAD;
      else if (ipc)             u = TGT_IPC;
      else if (irq)             u = TGT_IRQ;
      else if (a == ADDR_SHARE) u = TGT_SHARE;
      else if (math)            u = TGT_MATH;
      else                      u = TGT_NONE;
    end
    io_unit = u;
  endfunction

  // decode of every page other than I/O
  function automatic res_t mem_decode(input logic cpu, input logic wr,
                                      input logic [1:0] sz, input logic [31:0] addr,
                                      input logic [31:0] data, input logic [1:0] share);
    res_t r;
    logic half;
    r.target     = TGT_NONE;
    r.offset     = '0;
    r.width      = sz;
    r.data       = data;
    r.error_kind = ERR_NONE;
    r.last       = 1'b1;
    half         = addr[14];
    if (!cpu) begin
      unique case (addr[31:24])
        8'h00: begin
          if (wr) begin
            r.error_kind = (addr <= 32'h3FFF) ? ERR_ROMWR : ERR_INVALID;
          end else if (addr <= 32'h3FFF) begin
            r.target = TGT_BOOT2;
            r.offset = addr[23:0];
          end
        end
        8'h02: begin
          r.target = TGT_RAM;
          r.offset = {2'b00, addr[21:0]};
        end
        8'h03: begin
          if (share == 2'd0 || addr >= ADDR_PRIV_LO) begin
            r.target = TGT_PRIV;
            r.offset = {8'h00, addr[15:0]};
          end else begin
            unique case (share)
              2'd1:    r.target = TGT_HALF0;
              2'd2:    r.target = TGT_HALF1;
              default: r.target = half ? TGT_HALF1 : TGT_HALF0;
            endcase
            r.offset = {10'h000, addr[13:0]};
          end
        end
        8'h06: begin
          r.target = TGT_VIDMEM;
          r.offset = addr[23:0];
        end
        default: r.error_kind = ERR_INVALID;
      endcase
    end else begin
      unique case (addr[31:24])
        8'h00, 8'h01: r.target = TGT_NONE;
        8'h02: begin
          r.target = TGT_RAM;
          r.offset = {2'b00, addr[21:0]};
        end
        8'h03: begin
          if (share != 2'd3) begin
            unique case (share)
              2'd0:    r.target = half ? TGT_HALF1 : TGT_HALF0;
              2'd1:    r.target = TGT_HALF1;
              default: r.target = TGT_HALF0;
            endcase
            r.offset = {10'h000, addr[13:0]};
          end
        end
        8'h05: begin
          r.target = TGT_PAL;
          r.offset = {13'h0000, addr[10:0]};
        end
        8'h06: begin
          r.target = TGT_VIDMEM;
          r.offset = addr[23:0];
        end
        8'h07: begin
          r.target = TGT_SPRITE;
          r.offset = {13'h0000, addr[10:0]};
        end
        8'h08, 8'h09, 8'h0A: r.error_kind = ERR_CART;
        8'hFF: begin
          if (wr) begin
            r.error_kind = ERR_ROMWR;
          end else if (addr[15:0] <= 16'h7FFF) begin
            r.target = TGT_BOOT1;
            r.offset = {9'h000, addr[14:0]};
          end
        end
        default: r.error_kind = ERR_INVALID;
      endcase
    end
    mem_decode = r;
  endfunction

endpackage

/* hdl/dcmm_front.sv */
// ----------------------------------------------------------------------------
// dcmm_front
// Aligns an incoming request and classifies it: I/O page, IPC FIFO word,
// number of byte results.
// ----------------------------------------------------------------------------
module dcmm_front (
  input  logic           in_cpu,
  input  logic           in_mode,
  input  logic [1:0]     in_size,
  input  logic [31:0]    in_address,
  input  logic [31:0]    in_write_data,
  output dcmm_pkg::req_t req
);

  logic [1:0]  sz;
  logic [31:0] addr;
  logic        io;
  logic        fifo;

  always_comb begin
    sz   = in_size[1] ? dcmm_pkg::SZ_WORD : in_size;
    addr = in_address;
    unique case (sz)
      dcmm_pkg::SZ_WORD: addr[1:0] = 2'b00;
      dcmm_pkg::SZ_HALF: addr[0]   = 1'b0;
      default:           addr      = in_address;
    endcase
    io   = (addr[31:24] == 8'h04);
    fifo = io && (sz == dcmm_pkg::SZ_WORD) &&
           ((!in_mode && addr == dcmm_pkg::ADDR_FIFO_RD) ||
            (in_mode && addr == dcmm_pkg::ADDR_FIFO_WR));

    req.cpu  = in_cpu;
    req.wr   = in_mode;
    req.sz   = sz;
    req.addr = addr;
    req.wd   = in_write_data;
    req.io   = io;
    req.fifo = fifo;
    if (!in_mode) begin
      req.data = '0;
    end else begin
      unique case (sz)
        dcmm_pkg::SZ_BYTE: req.data = {24'h000000, in_write_data[7:0]};
        dcmm_pkg::SZ_HALF: req.data = {16'h0000, in_write_data[15:0]};
        default:           req.data = in_write_data;
      endcase
    end
    if (io && !fifo) begin
      unique case (sz)
        dcmm_pkg::SZ_BYTE: req.cnt_m1 = 2'd0;
        dcmm_pkg::SZ_HALF: req.cnt_m1 = 2'd1;
        default:           req.cnt_m1 = 2'd3;
      endcase
    end else begin
      req.cnt_m1 = 2'd0;
    end
  end

endmodule

/* hdl/dcmm_req_q.sv */
// ----------------------------------------------------------------------------
// dcmm_req_q
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module dcmm_req_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  dcmm_pkg::req_t wr_req,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output dcmm_pkg::req_t rd_req
);

  dcmm_pkg::req_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_req   = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_req;
    end
  end

endmodule

/* hdl/dcmm_back.sv */
// ----------------------------------------------------------------------------
// dcmm_back
// Decodes queued requests into results, one per cycle while the result queue
// has space, holds the sharing register and a two-entry result queue.
// ----------------------------------------------------------------------------
`include "dual_cpu_memory_map_decoder_macros.svh"

module dcmm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rq_valid,
  input  dcmm_pkg::req_t rq_head,
  output logic           rq_pop,
  input  logic           pop,
  output logic           empty,
  output dcmm_pkg::res_t res_head
);

  logic [1:0]     share_r, share_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic [31:0]    a;
  logic [4:0]     unit;
  logic [7:0]     byte_d;
  dcmm_pkg::res_t res;
  logic           produce;
  logic           share_we;

  dcmm_pkg::res_t oq_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           oq_pop;
  logic           oq_space;

  assign empty    = (cnt_r == 2'd0);
  assign res_head = oq_r[rp_r];
  assign oq_pop   = pop && !empty;
  assign oq_space = (cnt_r != 2'd2) || oq_pop;

  always_comb begin
    a      = {rq_head.addr[31:2], rq_head.addr[1:0] | idx_r};
    unit   = dcmm_pkg::io_unit(rq_head.cpu, rq_head.wr, a);
    byte_d = rq_head.wd[{idx_r, 3'b000} +: 8];
    if (!rq_head.io) begin
      res = dcmm_pkg::mem_decode(rq_head.cpu, rq_head.wr, rq_head.sz, rq_head.addr,
                                 rq_head.data, share_r);
    end else if (rq_head.fifo) begin
      res.target     = dcmm_pkg::TGT_IPCFIFO;
      res.offset     = rq_head.addr[23:0];
      res.width      = dcmm_pkg::SZ_WORD;
      res.data       = rq_head.data;
      res.error_kind = dcmm_pkg::ERR_NONE;
      res.last       = 1'b1;
    end else begin
      res.target = unit;
      res.offset = a[23:0];
      res.width  = dcmm_pkg::SZ_BYTE;
      if (rq_head.wr) begin
        res.data = {24'h000000, byte_d};
      end else if (unit == dcmm_pkg::TGT_SHARE) begin
        res.data = {30'h00000000, share_r};
      end else begin
        res.data = '0;
      end
      res.error_kind = (unit == dcmm_pkg::TGT_NONE) ? dcmm_pkg::ERR_IO : dcmm_pkg::ERR_NONE;
      res.last       = (idx_r == rq_head.cnt_m1);
    end

    produce  = rq_valid && oq_space;
    rq_pop   = produce && res.last;
    share_we = produce && rq_head.io && !rq_head.fifo && rq_head.wr &&
               (unit == dcmm_pkg::TGT_SHARE);

    share_nxt = share_we ? byte_d[1:0] : share_r;
    if (rq_pop) begin
      idx_nxt = 2'd0;
    end else if (produce) begin
      idx_nxt = idx_r + 2'd1;
    end else begin
      idx_nxt = idx_r;
    end

    wp_nxt  = produce ? ~wp_r : wp_r;
    rp_nxt  = oq_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, produce} - {1'b0, oq_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      share_r <= 2'd0;
      idx_r   <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      share_r <= share_nxt;
      idx_r   <= idx_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      oq_r[wp_r] <= res;
    end
  end

  `DCMM_ASSERT_NOW(a_oq_bound, 1'b1, cnt_r != 2'd3, "result queue overfilled")
  `DCMM_ASSERT_NOW(a_idx_bound, rq_valid, idx_r <= rq_head.cnt_m1, "byte index past request")
  `DCMM_ASSERT_NEXT(a_share_src, !share_we, $stable(share_r), "sharing changed without write")
  `DCMM_ASSERT_NOW(a_pop_last, rq_pop, produce && res.last, "request retired early")

endmodule

/* hdl/dual_cpu_memory_map_decoder.sv */
// ----------------------------------------------------------------------------
// dual_cpu_memory_map_decoder
// Decodes bus requests from two processors into target, offset and error.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the request queue is not full. Memory
// pages give one result, I/O page halfword and word requests give two or
// four byte results (the IPC FIFO word gives one); the back end emits one
// result per cycle while its result queue has space, so such a request holds
// the back end while a two-entry request queue keeps taking requests. Each
// request is registered in the request queue, its result in the result queue.
// Main core writes set the sharing register in request order; reset clears it.
// ----------------------------------------------------------------------------
module dual_cpu_memory_map_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_cpu,
  input  logic        in_mode,
  input  logic [1:0]  in_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_target,
  output logic [23:0] out_offset,
  output logic [1:0]  out_width,
  output logic [31:0] out_data,
  output logic [2:0]  out_error_kind,
  output logic        out_last
);

  dcmm_pkg::req_t front_req;
  dcmm_pkg::req_t rq_head;
  dcmm_pkg::res_t res_head;
  logic           rq_valid;
  logic           rq_pop;

  dcmm_front u_front (
    .in_cpu        (in_cpu),
    .in_mode       (in_mode),
    .in_size       (in_size),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .req           (front_req)
  );

  dcmm_req_q u_req_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_req   (front_req),
    .full     (full),
    .rd_en    (rq_pop),
    .rd_valid (rq_valid),
    .rd_req   (rq_head)
  );

  dcmm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rq_valid (rq_valid),
    .rq_head  (rq_head),
    .rq_pop   (rq_pop),
    .pop      (pop),
    .empty    (empty),
    .res_head (res_head)
  );

  assign out_target     = res_head.target;
  assign out_offset     = res_head.offset;
  assign out_width      = res_head.width;
  assign out_data       = res_head.data;
  assign out_error_kind = res_head.error_kind;
  assign out_last       = res_head.last;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory map decoder testbench
// Sends bus requests from both processors into the decoder, predicts every
// decode (including split I/O byte results and the shared RAM mapping) and
// checks each result in order, with random bursts, stalls and back pressure.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        cpu;
    logic        mode;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wd;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_cpu = 1'b0;
  logic        in_mode = 1'b0;
  logic [1:0]  in_size = 2'd0;
  logic [31:0] in_address = 32'd0;
  logic [31:0] in_write_data = 32'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  out_target;
  logic [23:0] out_offset;
  logic [1:0]  out_width;
  logic [31:0] out_data;
  logic [2:0]  out_error_kind;
  logic        out_last;

  dcmm_pkg::res_t pending_decodes[$];
  logic [1:0]     share_ctl = 2'd0;
  int             mismatches = 0;
  int             burst_left = 0;
  int             hold_cycles = 0;

  dual_cpu_memory_map_decoder DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_cpu(in_cpu), .in_mode(in_mode), .in_size(in_size),
    .in_address(in_address), .in_write_data(in_write_data),
    .empty(empty), .pop(pop),
    .out_target(out_target), .out_offset(out_offset), .out_width(out_width),
    .out_data(out_data), .out_error_kind(out_error_kind), .out_last(out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // unit behind one I/O page byte, o is the offset within the page
  function automatic logic [4:0] io_byte_unit(input logic main, input logic wr,
                                              input logic [23:0] o);
    logic kp, ipc, irq;
    kp  = (o == 24'h000132) || (o == 24'h000133) ||
          (!wr && (o == 24'h000130 || o == 24'h000131));
    ipc = (o == 24'h000180) || (o == 24'h000181) || (o == 24'h000184) ||
          (o == 24'h000185);
    irq = (o >= 24'h000208 && o <= 24'h00020B) || (o >= 24'h000210 && o <= 24'h000217);
    if (!main) begin
      if (o >= 24'h000004 && o <= 24'h000007) return dcmm_pkg::TGT_VIDIO;
      if (kp) return dcmm_pkg::TGT_KEYPAD;
      if (ipc) return dcmm_pkg::TGT_IPC;
      if (irq) return dcmm_pkg::TGT_IRQ;
      if (!wr && o == 24'h000240) return dcmm_pkg::TGT_VRSTAT;
      if (!wr && o == 24'h000241) return dcmm_pkg::TGT_SHARE;
      return dcmm_pkg::TGT_NONE;
    end
    if (o <= 24'h000058) return dcmm_pkg::TGT_VIDIO;
    if (wr && o >= 24'h000240 && o <= 24'h000249 &&
        o != dcmm_pkg::ADDR_SHARE[23:0])
      return dcmm_pkg::TGT_VIDIO;
    if (kp) return dcmm_pkg::TGT_KEYPAD;
    if (ipc) return dcmm_pkg::TGT_IPC;
    if (irq) return dcmm_pkg::TGT_IRQ;
    if (o == dcmm_pkg::ADDR_SHARE[23:0]) return dcmm_pkg::TGT_SHARE;
    if (o == 24'h000280 || o == 24'h000281 || (o >= 24'h000290 && o <= 24'h0002BF))
      return dcmm_pkg::TGT_MATH;
    return dcmm_pkg::TGT_NONE;
  endfunction

  function automatic void decode_request(input access_t a);
    logic [1:0]     w;
    logic [31:0]    ad, ba, dv, bd;
    logic [7:0]     pg;
    logic [4:0]     u;
    logic [1:0]     bank;
    logic           mapped;
    dcmm_pkg::res_t r;
    int             n;
    w  = (a.size >= dcmm_pkg::SZ_WORD) ? dcmm_pkg::SZ_WORD : a.size;
    ad = a.addr;
    if (w == dcmm_pkg::SZ_WORD) ad[1:0] = 2'b00;
    else if (w == dcmm_pkg::SZ_HALF) ad[0] = 1'b0;
    dv = !a.mode ? 32'd0 : (w == dcmm_pkg::SZ_BYTE) ? {24'd0, a.wd[7:0]} :
         (w == dcmm_pkg::SZ_HALF) ? {16'd0, a.wd[15:0]} : a.wd;
    pg = ad[31:24];
    r.target = dcmm_pkg::TGT_NONE;
    r.offset = '0;
    r.width = w;
    r.data = dv;
    r.error_kind = dcmm_pkg::ERR_NONE;
    r.last = 1'b1;
    if (pg == 8'h04) begin
      if (w == dcmm_pkg::SZ_WORD &&
          ((!a.mode && ad == dcmm_pkg::ADDR_FIFO_RD) ||
           (a.mode && ad == dcmm_pkg::ADDR_FIFO_WR))) begin
        r.target = dcmm_pkg::TGT_IPCFIFO;
        r.offset = ad[23:0];
        pending_decodes.push_back(r);
      end else begin
        n = 1 << w;
        for (int i = 0; i < n; i++) begin
          ba = ad + i;
          u  = io_byte_unit(a.cpu, a.mode, ba[23:0]);
          bd = a.mode ? ((a.wd >> (8 * i)) & 32'hFF) : 32'd0;
          if (u == dcmm_pkg::TGT_SHARE) begin
            if (a.mode) share_ctl = bd[1:0];
            else bd = {30'd0, share_ctl};
          end
          r.target = u;
          r.offset = ba[23:0];
          r.width = dcmm_pkg::SZ_BYTE;
          r.data = bd;
          r.error_kind = (u == dcmm_pkg::TGT_NONE) ? dcmm_pkg::ERR_IO : dcmm_pkg::ERR_NONE;
          r.last = (i == n - 1);
          pending_decodes.push_back(r);
        end
      end
      return;
    end
    if (!a.cpu) begin
      case (pg)
        8'h00: begin
          if (a.mode)
            r.error_kind = (ad <= 32'h3FFF) ? dcmm_pkg::ERR_ROMWR : dcmm_pkg::ERR_INVALID;
          else if (ad <= 32'h3FFF) begin
            r.target = dcmm_pkg::TGT_BOOT2;
            r.offset = ad[23:0];
          end
        end
        8'h02: begin
          r.target = dcmm_pkg::TGT_RAM;
          r.offset = {2'b00, ad[21:0]};
        end
        8'h03: begin
          mapped = (share_ctl != 2'd0) && (ad < dcmm_pkg::ADDR_PRIV_LO);
          bank = (share_ctl == 2'd3) ? {1'b0, ad[14]} : share_ctl - 2'd1;
          if (!mapped) begin
            r.target = dcmm_pkg::TGT_PRIV;
            r.offset = {8'h00, ad[15:0]};
          end else begin
            r.target = bank[0] ? dcmm_pkg::TGT_HALF1 : dcmm_pkg::TGT_HALF0;
            r.offset = {10'd0, ad[13:0]};
          end
        end
        8'h06: begin
          r.target = dcmm_pkg::TGT_VIDMEM;
          r.offset = ad[23:0];
        end
        default: r.error_kind = dcmm_pkg::ERR_INVALID;
      endcase
    end else begin
      case (pg)
        8'h00, 8'h01: ;
        8'h02: begin
          r.target = dcmm_pkg::TGT_RAM;
          r.offset = {2'b00, ad[21:0]};
        end
        8'h03: begin
          if (share_ctl != 2'd3) begin
            bank = (share_ctl == 2'd0) ? {1'b0, ad[14]} : {1'b0, ~share_ctl[1]};
            r.target = bank[0] ? dcmm_pkg::TGT_HALF1 : dcmm_pkg::TGT_HALF0;
            r.offset = {10'd0, ad[13:0]};
          end
        end
        8'h05: begin
          r.target = dcmm_pkg::TGT_PAL;
          r.offset = {13'd0, ad[10:0]};
        end
        8'h06: begin
          r.target = dcmm_pkg::TGT_VIDMEM;
          r.offset = ad[23:0];
        end
        8'h07: begin
          r.target = dcmm_pkg::TGT_SPRITE;
          r.offset = {13'd0, ad[10:0]};
        end
        8'h08, 8'h09, 8'h0A: r.error_kind = dcmm_pkg::ERR_CART;
        8'hFF: begin
          if (a.mode) r.error_kind = dcmm_pkg::ERR_ROMWR;
          else if (ad[15:0] <= 16'h7FFF) begin
            r.target = dcmm_pkg::TGT_BOOT1;
            r.offset = {9'd0, ad[14:0]};
          end
        end
        default: r.error_kind = dcmm_pkg::ERR_INVALID;
      endcase
    end
    pending_decodes.push_back(r);
  endfunction

  // called at a rising edge; leaves push high for the next request
  task automatic send_req(input logic cpu, input logic mode, input logic [1:0] size,
                          input logic [31:0] addr, input logic [31:0] wd);
    access_t a;
    a = '{cpu, mode, size, addr, wd};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_cpu <= cpu;
    in_mode <= mode;
    in_size <= size;
    in_address <= addr;
    in_write_data <= wd;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_request(a);
  endtask

  function automatic access_t random_access();
    access_t     a;
    logic [31:0] rnd;
    int          sel;
    logic [7:0]  pages[11];
    pages = '{8'h00, 8'h01, 8'h02, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'hFF, 8'h00};
    rnd = $urandom;
    a.cpu = 1'($urandom_range(0, 1));
    a.mode = 1'($urandom_range(0, 1));
    a.size = 2'($urandom_range(0, 3));
    a.wd = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      a.cpu = 1'b1;
      a.mode = 1'b1;
      a.size = dcmm_pkg::SZ_BYTE;
      a.addr = dcmm_pkg::ADDR_SHARE;
    end else if (sel < 42) begin
      case ($urandom_range(0, 9))
        0:       a.addr = {8'h04, rnd[23:0]};
        1:       a.addr = {8'h04, 12'h000, 4'h2, 4'h4, rnd[3:0] & 4'h9};
        2:       a.addr = a.mode ? dcmm_pkg::ADDR_FIFO_WR : dcmm_pkg::ADDR_FIFO_RD;
        3:       a.addr = dcmm_pkg::ADDR_SHARE & ~32'h7 | {29'd0, rnd[2:0]};
        default: a.addr = 32'h0400_0000 | $urandom_range(0, 32'h2C3);
      endcase
    end else if (sel < 64) begin
      a.addr = {8'h03, rnd[23:0]};
    end else if (sel < 94) begin
      a.addr = {pages[$urandom_range(0, 9)], rnd[23:0]};
      if (rnd[31]) a.addr[23:0] = 24'($urandom_range(0, 32'h8FFF));
    end else begin
      a.addr = rnd;
    end
    return a;
  endfunction

  task automatic send_random(input int count);
    access_t a;
    repeat (count) begin
      a = random_access();
      send_req(a.cpu, a.mode, a.size, a.addr, a.wd);
    end
  endtask

  task automatic test_memory_pages();
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_BYTE, 32'h0000_0000, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_WORD, 32'h0000_3FFF, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_HALF, 32'h0000_4001, 32'h0000_0000);
    send_req(1'b0, 1'b1, dcmm_pkg::SZ_BYTE, 32'h0000_0010, 32'hFFFF_FFFF);
    send_req(1'b0, 1'b1, dcmm_pkg::SZ_WORD, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    send_req(1'b1, 1'b0, 2'd3,              32'hFFFF_7FFF, 32'h0000_0000);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_BYTE, 32'hFFFF_8000, 32'h0000_0000);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_HALF, 32'h0800_0000, 32'h0000_0000);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_BYTE, 32'h0AFF_FFFF, 32'h0000_00A5);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_WORD, 32'h0123_4567, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_BYTE, 32'h0500_0000, 32'h0000_0000);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_HALF, 32'h0B00_0000, 32'h1234_5678);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_WORD, 32'h02FF_FFFF, 32'hDEAD_BEEF);
    send_req(1'b0, 1'b1, dcmm_pkg::SZ_HALF, 32'h06FF_FFFF, 32'h0000_FFFF);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_BYTE, 32'h05AB_CDEF, 32'h0000_0000);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_WORD, 32'h07FF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_io_units();
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_WORD, dcmm_pkg::ADDR_FIFO_WR, 32'h8765_4321);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_WORD, dcmm_pkg::ADDR_FIFO_RD, 32'h0000_0000);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_WORD, 32'h0400_0130, 32'h0000_0000);
    send_req(1'b0, 1'b1, dcmm_pkg::SZ_HALF, 32'h0400_0132, 32'h0000_FFFF);
    send_req(1'b0, 1'b1, dcmm_pkg::SZ_HALF, 32'h0400_0180, 32'h0000_BEEF);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_WORD, 32'h0400_020A, 32'hFFFF_FFFF);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_HALF, 32'h0400_0281, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_WORD, 32'h0400_0240, 32'h0000_0000);
    send_req(1'b0, 1'b1, dcmm_pkg::SZ_BYTE, 32'h0400_0241, 32'h0000_0003);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_WORD, 32'h0400_0054, 32'hA5A5_5A5A);
  endtask

  task automatic test_sharing_views();
    // byte three of the word lands on the sharing register
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_WORD, 32'h0400_0244, 32'h0300_0000);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_WORD, 32'h0300_4000, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_HALF, 32'h0300_4002, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_BYTE, 32'h0380_0000, 32'h0000_0000);
    send_req(1'b1, 1'b0, dcmm_pkg::SZ_BYTE, dcmm_pkg::ADDR_SHARE, 32'h0000_0000);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_BYTE, dcmm_pkg::ADDR_SHARE, 32'h0000_00FD);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_BYTE, 32'h037F_FFFF, 32'h0000_0000);
    send_req(1'b1, 1'b1, dcmm_pkg::SZ_BYTE, dcmm_pkg::ADDR_SHARE, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_WORD, 32'h0300_0000, 32'h0000_0000);
    send_req(1'b0, 1'b0, dcmm_pkg::SZ_BYTE, 32'h0400_0241, 32'h0000_0000);
  endtask

  task automatic test_back_pressure();
    hold_cycles = 80;
    send_random(24);
  endtask

  task automatic test_random_mix(input int count);
    send_random(count);
  endtask

  // result side: stall pattern, long hold-off and in-order checking
  initial begin
    logic [15:0]    stall_bits;
    int             phase_left;
    dcmm_pkg::res_t e;
    stall_bits = '1;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (pending_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no request pending: tgt=%0d off=%h", out_target, out_offset);
        end else begin
          e = pending_decodes.pop_front();
          if (out_target !== e.target || out_offset !== e.offset || out_width !== e.width ||
              out_data !== e.data || out_error_kind !== e.error_kind || out_last !== e.last)
          begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("decode mismatch: exp tgt=%0d off=%h w=%0d data=%h err=%0d last=%b",
                       e.target, e.offset, e.width, e.data, e.error_kind, e.last);
              $display("                 got tgt=%0d off=%h w=%0d data=%h err=%0d last=%b",
                       out_target, out_offset, out_width, out_data, out_error_kind,
                       out_last);
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 64);
          stall_bits = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end
        phase_left--;
        pop <= stall_bits[0];
        stall_bits = {stall_bits[0], stall_bits[15:1]};
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_memory_pages();
    test_io_units();
    test_sharing_views();
    test_random_mix(150);
    test_back_pressure();
    test_random_mix(170);
    push <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
